FILE: hw/rtl/tts_pkg.sv
package tts_pkg;

  localparam int STORE_DEPTH = 63;
  localparam int FILL_W      = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CSI    = 8'h5b;
  localparam logic [7:0] FINAL_LO  = 8'h40;
  localparam logic [7:0] FINAL_HI  = 8'h7e;

  typedef enum logic [1:0] {
    ESC_TEXT  = 2'd0,
    ESC_START = 2'd1,
    ESC_CSI   = 2'd2
  } esc_mode_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_CLEAR,
    OP_BKSP,
    OP_LINE,
    OP_FLUSH
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND,
    BK_NEWLINE
  } back_state_t;

endpackage

FILE: hw/rtl/tts_if.sv
interface tts_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_byte;

  modport source (output valid, output cmd, output in_byte, input ready);
  modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

interface tts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       truncated;

  modport source (output valid, output out_byte, output last, output truncated,
                  input ready);
  modport sink   (input valid, input out_byte, input last, input truncated,
                  output ready);
endinterface

FILE: hw/rtl/tts_front.sv
module tts_front
  import tts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_byte,
  input  q_stat_t    q_stat,
  output logic       q_push,
  output op_t        q_op
);

  esc_mode_t mode_r, mode_nxt;
  logic      accept;
  logic      final_byte;
  logic      emit_op;

  assign in_ready   = !q_stat.full;
  assign accept     = in_valid && !q_stat.full;
  assign final_byte = (in_byte >= FINAL_LO) && (in_byte <= FINAL_HI);

  always_comb begin
    mode_nxt     = mode_r;
    emit_op      = 1'b0;
    q_op.kind    = OP_PUSH;
    q_op.data    = in_byte;
    if (in_cmd) begin
      mode_nxt  = ESC_TEXT;
      emit_op   = 1'b1;
      q_op.kind = OP_FLUSH;
    end else begin
      case (mode_r)
        ESC_TEXT: begin
          if (in_byte == CH_ESC) begin
            mode_nxt = ESC_START;
          end else if (in_byte == CH_CR) begin
            emit_op   = 1'b1;
            q_op.kind = OP_CLEAR;
          end else if (in_byte == CH_LF) begin
            emit_op   = 1'b1;
            q_op.kind = OP_LINE;
          end else if (in_byte == CH_BS) begin
            emit_op   = 1'b1;
            q_op.kind = OP_BKSP;
          end else if (in_byte >= CH_SPACE || in_byte == CH_TAB) begin
            emit_op   = 1'b1;
            q_op.kind = OP_PUSH;
          end
        end
        ESC_START: begin
          if (in_byte == CH_CSI) begin
            mode_nxt = ESC_CSI;
          end else if (final_byte) begin
            mode_nxt = ESC_TEXT;
          end
        end
        default: begin
          // inside CSI: drop parameter and intermediate bytes
          if (final_byte) begin
            mode_nxt = ESC_TEXT;
          end
        end
      endcase
    end
  end

  assign q_push = accept && emit_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ESC_TEXT;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

FILE: hw/rtl/tts_queue.sv
module tts_queue
  import tts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  op_t     push_op,
  input  logic    pop,
  output op_t     pop_op,
  output q_stat_t stat
);

  op_t                entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W:0]    count_r;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_op     = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: hw/rtl/tts_back.sv
module tts_back
  import tts_pkg::*;
#(
  parameter int LINE_CAPACITY = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  q_stat_t    q_stat,
  input  op_t        q_op,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_truncated
);

  localparam logic [FILL_W-1:0] CAP = FILL_W'(LINE_CAPACITY);

  logic [7:0]        line_mem [STORE_DEPTH];
  back_state_t       state_r, state_nxt;
  logic [FILL_W-1:0] fill_r;
  logic              ovf_r;
  logic [FILL_W-1:0] len_r;
  logic [FILL_W-1:0] idx_r;
  logic              nl_r;
  logic              trunc_r;
  logic [7:0]        rd_data_r;

  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic              out_trunc_r;

  logic              slot_free;
  logic              load_byte;
  logic              load_nl;
  logic              last_stored;
  logic              is_emit;

  assign slot_free   = !out_valid_r || out_ready;
  assign last_stored = (idx_r + 1'b1) == len_r;
  assign is_emit     = (q_op.kind == OP_LINE) || (q_op.kind == OP_FLUSH);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty && is_emit) begin
          if (fill_r != '0) begin
            state_nxt = BK_READ;
          end else if (q_op.kind == OP_LINE) begin
            state_nxt = BK_NEWLINE;
          end
        end
      end
      BK_READ: state_nxt = BK_SEND;
      BK_SEND: begin
        if (slot_free) begin
          if (!last_stored) begin
            state_nxt = BK_READ;
          end else if (nl_r) begin
            state_nxt = BK_NEWLINE;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_NEWLINE: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    q_pop     = 1'b0;
    load_byte = 1'b0;
    load_nl   = 1'b0;
    case (state_r)
      BK_IDLE:    q_pop     = !q_stat.empty;
      BK_SEND:    load_byte = slot_free;
      BK_NEWLINE: load_nl   = slot_free;
      default:    q_pop     = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_op.kind == OP_PUSH && fill_r < CAP) begin
      line_mem[fill_r] <= q_op.data;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_READ) begin
      rd_data_r <= line_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        case (q_op.kind)
          OP_PUSH: begin
            if (fill_r < CAP) begin
              fill_r <= fill_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
          end
          OP_BKSP: begin
            if (fill_r != '0) begin
              fill_r <= fill_r - 1'b1;
            end
          end
          OP_CLEAR, OP_LINE, OP_FLUSH: begin
            fill_r <= '0;
            ovf_r  <= 1'b0;
          end
          default: fill_r <= fill_r;
        endcase
      end
    end
  end

  // snapshot of the line being read out; the store is free for reuse after
  always_ff @(posedge clk) begin
    if (q_pop && is_emit) begin
      len_r   <= fill_r;
      nl_r    <= (q_op.kind == OP_LINE);
      trunc_r <= ovf_r;
      idx_r   <= '0;
    end else if (load_byte) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_byte || load_nl) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      out_byte_r  <= rd_data_r;
      out_last_r  <= last_stored && !nl_r;
      out_trunc_r <= trunc_r;
    end else if (load_nl) begin
      out_byte_r  <= CH_LF;
      out_last_r  <= 1'b1;
      out_trunc_r <= trunc_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last      = out_last_r;
  assign out_truncated = out_trunc_r;

endmodule

FILE: hw/rtl/terminal_text_sanitizer.sv
// Terminal text sanitizer: strips escape sequences (ESC, and CSI up to its
// final byte 0x40..0x7e) from a terminal byte stream and keeps the current
// line, up to LINE_CAPACITY bytes, in a 63-entry line store. Data bytes are
// taken one per cycle by the front end while the queue is not full and queued
// as line operations in a 4-entry queue; the back end retires one queued
// operation per cycle while idle, and none during a readout. A newline or
// end-of-stream command reads the stored line out through the store's single
// registered read port: each stored byte is read, then sent, and a newline
// byte follows for a newline command, subject to out.ready. During readout
// input is still taken until the queue fills, then in.ready drops. Bytes
// beyond capacity are dropped and every byte of that line's run carries
// truncated. An end-of-stream command on an empty line gives no output.
module terminal_text_sanitizer
  import tts_pkg::*;
#(
  parameter int LINE_CAPACITY = 63
) (
  input  logic     clk,
  input  logic     rst_n,
  tts_in_if.sink   in_ch,
  tts_out_if.source out_ch
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  op_t     q_push_op;
  op_t     q_pop_op;

  tts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_cmd   (in_ch.cmd),
    .in_byte  (in_ch.in_byte),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_op     (q_push_op)
  );

  tts_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_push_op),
    .pop     (q_pop),
    .pop_op  (q_pop_op),
    .stat    (q_stat)
  );

  tts_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_op          (q_pop_op),
    .q_pop         (q_pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_byte      (out_ch.out_byte),
    .out_last      (out_ch.last),
    .out_truncated (out_ch.truncated)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_newline_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_byte == CH_LF) |-> out_ch.last)
    else $error("newline byte not at end of run");

  a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd) |-> q_push)
    else $error("end-of-stream command not queued");

endmodule
